// ===== sv/gam_pkg.sv =====
// ----------------------------------------------------------------------------
// gam_pkg
// Shared types and constants for the gamepad action mapper.
// ----------------------------------------------------------------------------
`default_nettype none
package gam_pkg;
    localparam int unsigned BindW  = 55;
    localparam int unsigned AxisW  = 16;
    localparam int unsigned TimeW  = 32;
    localparam int unsigned NearZeroMax = 163;

    localparam logic [2:0] ACT_TOGGLE_TC = 3'd0;
    localparam logic [2:0] ACT_THROTTLE  = 3'd4;

    // decision of one lane for one binding
    typedef struct packed {
        logic       fire;
        logic [2:0] mtype;
        logic [7:0] level;
        logic       upd_time;
        logic       upd_value;
        logic       value_zero;
    } lane_res_t;

    // merged result message
    typedef struct packed {
        logic [2:0] mtype;
        logic [7:0] level;
        logic [2:0] index;
    } msg_t;
endpackage
`default_nettype wire

// ===== sv/gam_lane.sv =====
// ----------------------------------------------------------------------------
// gam_lane
// Evaluates one binding against the registered snapshot.
// ----------------------------------------------------------------------------
`default_nettype none
module gam_lane #(
    parameter int unsigned NUM_BUTTONS = 16,
    parameter int unsigned NUM_AXES    = 6
) (
    input  wire logic [gam_pkg::BindW-1:0]            binding,
    input  wire logic [15:0]                          cur_buttons,
    input  wire logic [15:0]                          prev_buttons,
    input  wire logic signed [gam_pkg::AxisW-1:0]     cur_axis,
    input  wire logic signed [gam_pkg::AxisW-1:0]     prev_axis,
    input  wire logic signed [gam_pkg::AxisW-1:0]     last_value,
    input  wire logic [gam_pkg::TimeW-1:0]            last_time,
    input  wire logic                                 sent,
    input  wire logic [gam_pkg::TimeW-1:0]            now_ms,
    output gam_pkg::lane_res_t                        res
);
    import gam_pkg::*;

    logic        en, is_axis, ivl_ok, pb, cb, pa, ca, near0;
    logic [3:0]  idx;
    logic [2:0]  act, mtype;
    logic [16:0] thr, dthr, acur, aprev, delta;
    logic [15:0] ivl;
    logic [31:0] elapsed;
    logic signed [17:0] diff;
    logic [24:0] prod;
    logic [7:0]  lvl;

    // field decode
    always_comb begin
        en      = binding[0];
        is_axis = binding[1];
        idx     = binding[5:2];
        act     = binding[8:6];
        thr     = {2'b00, binding[23:9]};
        dthr    = {2'b00, binding[38:24]};
        ivl     = binding[54:39];
        mtype   = (act <= ACT_THROTTLE) ? act : ACT_TOGGLE_TC;
    end

    // magnitudes, interval and mapped level
    always_comb begin
        elapsed = now_ms - last_time;
        ivl_ok  = !sent || (elapsed >= {16'd0, ivl});
        pb      = prev_buttons[idx];
        cb      = cur_buttons[idx];
        acur    = cur_axis[15] ? 17'(-{cur_axis[15], cur_axis}) : {1'b0, cur_axis};
        aprev   = prev_axis[15] ? 17'(-{prev_axis[15], prev_axis}) : {1'b0, prev_axis};
        pa      = aprev >= thr;
        ca      = acur >= thr;
        diff    = 18'(cur_axis) - 18'(last_value);
        delta   = diff[17] ? 17'(-diff) : diff[16:0];
        near0   = cur_axis <= $signed(16'(NearZeroMax));
        prod    = {10'd0, cur_axis[14:0]} * 25'd255 + 25'd8192;
        if (cur_axis <= 0)            lvl = 8'd0;
        else if (cur_axis >= 16384)   lvl = 8'd255;
        else                          lvl = prod[21:14];
    end

    // binding decision
    always_comb begin
        res = '0;
        if (en) begin
            if (!is_axis) begin
                if (idx < NUM_BUTTONS && pb != cb) begin
                    if (act != ACT_THROTTLE) begin
                        res.fire  = cb;
                        res.mtype = mtype;
                    end else begin
                        res.fire  = 1'b1;
                        res.mtype = ACT_THROTTLE;
                        res.level = cb ? 8'd255 : 8'd0;
                    end
                end
            end else if (idx < NUM_AXES) begin
                if (act != ACT_THROTTLE) begin
                    if (!pa && ca && ivl_ok) begin
                        res.fire     = 1'b1;
                        res.mtype    = mtype;
                        res.upd_time = 1'b1;
                    end
                end else if (near0 && last_value > 0) begin
                    res.fire       = 1'b1;
                    res.mtype      = ACT_THROTTLE;
                    res.upd_time   = 1'b1;
                    res.upd_value  = 1'b1;
                    res.value_zero = 1'b1;
                end else if (delta >= dthr && ivl_ok) begin
                    res.fire      = 1'b1;
                    res.mtype     = ACT_THROTTLE;
                    res.level     = lvl;
                    res.upd_time  = 1'b1;
                    res.upd_value = 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== sv/gamepad_action_mapper_unit.sv =====
// ----------------------------------------------------------------------------
// gamepad_action_mapper_unit
// Maps controller snapshots to binding action messages.
// ----------------------------------------------------------------------------
// One snapshot is accepted, then all bindings are evaluated at once in
// parallel lanes; the merge stage then emits the firing bindings in index
// order, one message beat per cycle while the result side does not stall,
// at most NUM_BINDINGS beats per snapshot. A new snapshot is taken once the
// last beat leaves, or after evaluation when no binding fires.
`default_nettype none
module gamepad_action_mapper_unit #(
    parameter int unsigned NUM_BINDINGS = 8,
    parameter int unsigned NUM_BUTTONS  = 16,
    parameter int unsigned NUM_AXES     = 6
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_we,
    input  wire logic [2:0]                cfg_index,
    input  wire logic [gam_pkg::BindW-1:0] cfg_data,
    input  wire logic                      s_valid,
    output      logic                      s_ready,
    input  wire logic                      s_connected,
    input  wire logic [15:0]               s_buttons,
    input  wire logic signed [15:0]        s_axis_0,
    input  wire logic signed [15:0]        s_axis_1,
    input  wire logic signed [15:0]        s_axis_2,
    input  wire logic signed [15:0]        s_axis_3,
    input  wire logic signed [15:0]        s_axis_4,
    input  wire logic signed [15:0]        s_axis_5,
    input  wire logic [31:0]               s_now_ms,
    output      logic                      m_valid,
    input  wire logic                      m_ready,
    output      logic [2:0]                m_message_type,
    output      logic [7:0]                m_throttle,
    output      logic [2:0]                m_binding_index,
    output      logic                      m_last
);
    import gam_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_EMIT} state_t;

    state_t state_reg;
    logic [BindW-1:0] bind_reg [NUM_BINDINGS];
    logic [15:0] prev_btn_reg, cur_btn_reg;
    logic signed [15:0] prev_axes_reg [6];
    logic signed [15:0] cur_axes_reg  [6];
    logic signed [15:0] lsv_reg [NUM_BINDINGS];
    logic [31:0] lst_reg [NUM_BINDINGS];
    logic [NUM_BINDINGS-1:0] sent_reg, pend_reg;
    logic conn_reg;
    logic [31:0] now_reg;
    msg_t msg_reg [NUM_BINDINGS];
    lane_res_t res [NUM_BINDINGS];
    logic signed [15:0] in_axes [6];
    logic [NUM_BINDINGS-1:0] fire_vec, rest;
    logic [2:0] sel;

    assign in_axes = '{s_axis_0, s_axis_1, s_axis_2, s_axis_3, s_axis_4, s_axis_5};
    assign s_ready = (state_reg == ST_IDLE);

    // lanes
    for (genvar g = 0; g < NUM_BINDINGS; g++) begin : g_lane
        logic [3:0] ai;
        assign ai = bind_reg[g][5:2];
        gam_lane #(.NUM_BUTTONS(NUM_BUTTONS), .NUM_AXES(NUM_AXES)) u_lane (
            .binding(bind_reg[g]), .cur_buttons(cur_btn_reg),
            .prev_buttons(prev_btn_reg),
            .cur_axis(cur_axes_reg[(ai < 4'd6) ? ai[2:0] : 3'd0]),
            .prev_axis(prev_axes_reg[(ai < 4'd6) ? ai[2:0] : 3'd0]),
            .last_value(lsv_reg[g]), .last_time(lst_reg[g]), .sent(sent_reg[g]),
            .now_ms(now_reg), .res(res[g]));
        assign fire_vec[g] = res[g].fire & conn_reg;
    end

    // merge: lowest pending binding and whether more follow
    always_comb begin
        sel = '0;
        for (int k = NUM_BINDINGS - 1; k >= 0; k--)
            if (pend_reg[k]) sel = 3'(k);
        rest = pend_reg;
        rest[sel] = 1'b0;
    end

    assign m_valid         = (state_reg == ST_EMIT);
    assign m_message_type  = msg_reg[sel].mtype;
    assign m_throttle      = msg_reg[sel].level;
    assign m_binding_index = msg_reg[sel].index;
    assign m_last          = (rest == '0);

    // configuration and sequencing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pend_reg     <= '0;
            sent_reg     <= '0;
            prev_btn_reg <= '0;
            for (int k = 0; k < 6; k++) prev_axes_reg[k] <= '0;
            for (int k = 0; k < NUM_BINDINGS; k++) begin
                bind_reg[k] <= '0;
                lsv_reg[k]  <= '0;
                lst_reg[k]  <= '0;
            end
        end else begin
            if (cfg_we && 32'(cfg_index) < NUM_BINDINGS)
                bind_reg[cfg_index] <= cfg_data;
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        conn_reg    <= s_connected;
                        cur_btn_reg <= s_buttons;
                        now_reg     <= s_now_ms;
                        for (int k = 0; k < 6; k++) cur_axes_reg[k] <= in_axes[k];
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    for (int k = 0; k < NUM_BINDINGS; k++) begin
                        msg_reg[k] <= '{res[k].mtype, res[k].level, 3'(k)};
                        if (fire_vec[k] && res[k].upd_time) begin
                            lst_reg[k]  <= now_reg;
                            sent_reg[k] <= 1'b1;
                        end
                        if (fire_vec[k] && res[k].upd_value)
                            lsv_reg[k] <= res[k].value_zero ? 16'sd0
                                : cur_axes_reg[bind_reg[k][4:2]];
                    end
                    pend_reg     <= fire_vec;
                    prev_btn_reg <= cur_btn_reg;
                    for (int k = 0; k < 6; k++) prev_axes_reg[k] <= cur_axes_reg[k];
                    state_reg <= (fire_vec != '0) ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT: begin
                    if (m_ready) begin
                        pend_reg <= rest;
                        if (rest == '0) state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== sv/gam_checker.sv =====
// ----------------------------------------------------------------------------
// gam_checker
// Port-level checks on the gamepad action mapper.
// ----------------------------------------------------------------------------
`default_nettype none
module gam_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_last,
    input wire logic [2:0] m_message_type,
    input wire logic [7:0] m_throttle
);
    import gam_pkg::*;

    // no new snapshot while beats are pending
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("ready while emitting");
    // a stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_message_type))
        else $error("beat dropped");
    // only throttle messages carry a level
    a_lvl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_message_type != ACT_THROTTLE |-> m_throttle == 8'd0)
        else $error("level on binary message");
    // after a last beat the block is ready again
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last |=> s_ready) else $error("stuck after last");
endmodule

bind gamepad_action_mapper_unit gam_checker u_gam_checker (.*);
`default_nettype wire

// ===== bench/tb_gamepad_action_mapper_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gamepad_action_mapper_unit
// Self-checking bench for the gamepad action mapper. Snapshots are driven
// over valid/ready, and a scoreboard predicts the messages of every binding.
// It checks each result beat field by field in order, under random stalls
// on both sides and several binding setups.
// ----------------------------------------------------------------------------
`default_nettype none

// expected message of one binding for one snapshot
typedef struct {
    logic [2:0] mtype;
    logic [7:0] level;
    logic [2:0] index;
    logic       last;
} gam_msg_t;

class gam_scoreboard;
    logic [54:0]        bind_word [8];
    logic [15:0]        prev_buttons;
    logic signed [15:0] prev_axes [6];
    logic signed [15:0] sent_value [8];
    logic [31:0]        sent_time [8];
    bit                 has_sent [8];
    gam_msg_t           pending [$];
    int                 errors;
    int                 beats;

    function new();
        for (int i = 0; i < 8; i++) begin
            bind_word[i] = '0;
            sent_value[i] = '0;
            sent_time[i] = '0;
            has_sent[i] = 0;
        end
        for (int i = 0; i < 6; i++) prev_axes[i] = '0;
        prev_buttons = '0;
        errors = 0;
        beats = 0;
    endfunction

    function automatic logic [7:0] level_of(int v);
        if (v <= 0) return 8'd0;
        if (v >= 16384) return 8'd255;
        return 8'((v * 255 + 8192) >>> 14);
    endfunction

    function automatic int mag(int v);
        return (v < 0) ? -v : v;
    endfunction

    // predict the messages of one accepted snapshot
    function void note_snapshot(logic conn, logic [15:0] btn,
                                logic signed [15:0] ax [6], logic [31:0] now);
        gam_msg_t m;
        int n;
        n = 0;
        if (conn) begin
            for (int i = 0; i < 8; i++) begin
                logic [54:0] w;
                logic [3:0]  idx;
                logic [2:0]  act, mt;
                int          thr, dthr, cur, prv;
                logic [15:0] ivl;
                bit          ivl_ok, fire;
                logic [7:0]  lvl;
                w = bind_word[i];
                idx = w[5:2];
                act = w[8:6];
                thr = int'(w[23:9]);
                dthr = int'(w[38:24]);
                ivl = w[54:39];
                mt = (act <= gam_pkg::ACT_THROTTLE) ? act : gam_pkg::ACT_TOGGLE_TC;
                fire = 0;
                lvl = 8'd0;
                if (!w[0]) continue;
                if (!w[1]) begin
                    if (prev_buttons[idx] == btn[idx]) continue;
                    if (act != gam_pkg::ACT_THROTTLE) fire = btn[idx];
                    else begin
                        fire = 1;
                        lvl = btn[idx] ? 8'd255 : 8'd0;
                    end
                end else begin
                    if (idx >= 6) continue;
                    ivl_ok = !has_sent[i] || (now - sent_time[i]) >= {16'd0, ivl};
                    cur = int'(ax[idx]);
                    if (act != gam_pkg::ACT_THROTTLE) begin
                        if (mag(int'(prev_axes[idx])) < thr && mag(cur) >= thr && ivl_ok)
                            fire = 1;
                    end else begin
                        prv = int'(sent_value[i]);
                        if (cur <= int'(gam_pkg::NearZeroMax) && prv > 0) begin
                            fire = 1;
                            sent_value[i] = '0;
                        end else if (mag(cur - prv) >= dthr && ivl_ok) begin
                            fire = 1;
                            lvl = level_of(cur);
                            sent_value[i] = ax[idx];
                        end
                    end
                    if (fire) begin
                        sent_time[i] = now;
                        has_sent[i] = 1;
                    end
                end
                if (fire) begin
                    m.mtype = mt;
                    m.level = lvl;
                    m.index = 3'(i);
                    m.last = 0;
                    pending = {pending, m};
                    n++;
                end
            end
        end
        if (n > 0) pending[pending.size() - 1].last = 1;
        prev_buttons = btn;
        for (int i = 0; i < 6; i++) prev_axes[i] = ax[i];
    endfunction

    task report(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    // compare one result beat with the oldest expectation
    task check_message(logic [2:0] mt, logic [7:0] lv, logic [2:0] ix, logic ls);
        gam_msg_t e;
        beats++;
        if (pending.size() == 0) begin
            report("unexpected beat, index", ix, -1);
            return;
        end
        e = pending.pop_front();
        if (mt !== e.mtype) report("message_type", mt, e.mtype);
        if (lv !== e.level) report("throttle", lv, e.level);
        if (ix !== e.index) report("binding_index", ix, e.index);
        if (ls !== e.last) report("last", ls, e.last);
    endtask
endclass

module tb_gamepad_action_mapper_unit;
    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_we = 0;
    logic [2:0] cfg_index = '0;
    logic [54:0] cfg_data = '0;
    logic s_valid = 0;
    logic s_ready;
    logic s_connected = 0;
    logic [15:0] s_buttons = '0;
    logic signed [15:0] s_axis_0 = '0, s_axis_1 = '0, s_axis_2 = '0;
    logic signed [15:0] s_axis_3 = '0, s_axis_4 = '0, s_axis_5 = '0;
    logic [31:0] s_now_ms = '0;
    logic m_valid;
    logic m_ready = 0;
    logic [2:0] m_message_type;
    logic [7:0] m_throttle;
    logic [2:0] m_binding_index;
    logic m_last;

    gam_scoreboard board = new();
    bit calm = 0;
    bit hold_sink = 0;
    bit hold_done = 0;
    int snapshots = 0;
    logic [31:0] clock_ms = 32'd1000;
    logic signed [15:0] cur_axes [6];

    always #10 aclk = ~aclk;

    gamepad_action_mapper_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_connected(s_connected),
        .s_buttons(s_buttons),
        .s_axis_0(s_axis_0), .s_axis_1(s_axis_1), .s_axis_2(s_axis_2),
        .s_axis_3(s_axis_3), .s_axis_4(s_axis_4), .s_axis_5(s_axis_5),
        .s_now_ms(s_now_ms),
        .m_valid(m_valid), .m_ready(m_ready), .m_message_type(m_message_type),
        .m_throttle(m_throttle), .m_binding_index(m_binding_index), .m_last(m_last)
    );

    // result side: random stalls, one long hold-off, checking on each beat
    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_sink && !hold_done) begin
                m_ready <= 0;
                repeat (300) @(posedge aclk);
                hold_done = 1;
            end
            if (!calm && $urandom_range(3) == 0) begin
                gap = $urandom_range(18, 1);
                m_ready <= 0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk);
            if (m_valid && m_ready)
                board.check_message(m_message_type, m_throttle, m_binding_index, m_last);
        end
    end

    task write_binding(int idx, logic [54:0] w);
        cfg_we <= 1;
        cfg_index <= 3'(idx);
        cfg_data <= w;
        @(posedge aclk);
        cfg_we <= 0;
        board.bind_word[idx] = w;
        @(posedge aclk);
    endtask

    function automatic logic [54:0] pack_binding(bit en, bit axis, int idx, int act,
                                                 int thr, int dthr, int ivl);
        return {16'(ivl), 15'(dthr), 15'(thr), 3'(act), 4'(idx), axis, en};
    endfunction

    // send one snapshot beat and predict on acceptance
    task send_snapshot(logic conn, logic [15:0] btn, logic [31:0] now);
        int gap;
        if (!calm && $urandom_range(3) == 0) begin
            gap = $urandom_range(18, 1);
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_connected <= conn;
        s_buttons <= btn;
        s_axis_0 <= cur_axes[0]; s_axis_1 <= cur_axes[1]; s_axis_2 <= cur_axes[2];
        s_axis_3 <= cur_axes[3]; s_axis_4 <= cur_axes[4]; s_axis_5 <= cur_axes[5];
        s_now_ms <= now;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_snapshot(conn, btn, cur_axes, now);
        snapshots++;
    endtask

    task wait_drained();
        s_valid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic signed [15:0] rand_axis();
        case ($urandom_range(5))
            0: return 16'($urandom);
            1: return 16'sd16384;
            2: return -16'sd16384;
            3: return 16'($urandom_range(200));
            default: return 16'($urandom_range(32768) - 16384);
        endcase
    endfunction

    // random binding, mostly well-formed, sometimes out of range
    function automatic logic [54:0] rand_binding(int mode);
        bit axis;
        axis = $urandom_range(1);
        if (mode == 0) return 55'({$urandom, $urandom});
        return pack_binding($urandom_range(7) != 0, axis,
                            axis ? $urandom_range(6) : $urandom_range(15),
                            ($urandom_range(4) == 0) ? $urandom_range(7) : 4 * $urandom_range(1),
                            $urandom_range(16384), $urandom_range(3000),
                            ($urandom_range(2) == 0) ? 0 : $urandom_range(60));
    endfunction

    task random_snapshots(int count);
        for (int k = 0; k < count; k++) begin
            for (int a = 0; a < 6; a++)
                if ($urandom_range(2) == 0) cur_axes[a] = rand_axis();
            clock_ms += $urandom_range(40);
            if ($urandom_range(30) == 0) clock_ms = 32'($urandom);
            send_snapshot($urandom_range(9) != 0, 16'($urandom), clock_ms);
        end
    endtask

    initial begin
        for (int a = 0; a < 6; a++) cur_axes[a] = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed setup: one binding of each kind
        write_binding(0, pack_binding(1, 0, 0, 0, 0, 0, 0));
        write_binding(1, pack_binding(1, 0, 15, 4, 0, 0, 0));
        write_binding(2, pack_binding(1, 1, 0, 1, 8192, 0, 10));
        write_binding(3, pack_binding(1, 1, 1, 4, 0, 500, 0));
        write_binding(4, pack_binding(1, 1, 5, 2, 32767, 0, 65535));
        write_binding(5, pack_binding(1, 0, 3, 7, 0, 0, 0));
        write_binding(6, pack_binding(1, 1, 6, 3, 0, 0, 0));
        write_binding(7, pack_binding(1, 0, 2, 3, 0, 32767, 0));
        send_snapshot(1, 16'hFFFF, 32'd0);
        cur_axes[0] = 16'sd16384; cur_axes[1] = 16'sd16384;
        send_snapshot(1, 16'h0000, 32'd5);
        cur_axes[0] = 16'sd0; cur_axes[1] = 16'sd100;
        send_snapshot(1, 16'h8009, 32'd8);
        cur_axes[0] = -16'sd16384; cur_axes[1] = 16'sd163;
        send_snapshot(1, 16'h0000, 32'd20);
        cur_axes[1] = 16'sd164; cur_axes[5] = 16'sh7FFF;
        send_snapshot(0, 16'hFFFF, 32'd30);
        cur_axes[1] = 16'sh8000; cur_axes[0] = 16'sd0;
        send_snapshot(1, 16'h0000, 32'hFFFF_FFF0);
        cur_axes[0] = 16'sh7FFF; cur_axes[1] = 16'sd12000;
        send_snapshot(1, 16'h8000, 32'd4);
        cur_axes[1] = 16'sd164;
        send_snapshot(1, 16'h0000, 32'd200);
        wait_drained();

        // random setups, extremes among them
        for (int phase = 0; phase < 6; phase++) begin
            for (int b = 0; b < 8; b++) begin
                if (phase == 1) write_binding(b, {55{1'b1}});
                else if (phase == 2) write_binding(b, pack_binding(1, b % 2, b % 6, 4,
                                                                  0, 0, 0));
                else write_binding(b, rand_binding(phase == 3 ? 0 : 1));
            end
            if (phase == 2) hold_sink = 1;
            if (phase == 5) calm = 1;
            random_snapshots(phase == 1 ? 20 : 58);
            wait_drained();
        end

        $display("covered %0d snapshots and %0d message beats", snapshots, board.beats);
        $display("directed edges, random bindings and a long result stall included");
        if (board.errors == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #(20ns * 400000);
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end
endmodule

`default_nettype wire
